/* rtl/core/uv_sphere_vertex_generator_top_assert.svh */
// Assertion macros for the UV sphere vertex generator checker
`ifndef UV_SPHERE_VERTEX_GENERATOR_TOP_ASSERT_SVH
`define UV_SPHERE_VERTEX_GENERATOR_TOP_ASSERT_SVH

// hold a stalled output beat
`define UVS_ASSERT_HOLD(label, vld, rdy, sig) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        ((vld) && !(rdy)) |=> ((vld) && $stable(sig))) \
        else $error("stalled output beat changed");

// implication within one output beat
`define UVS_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (ante) |-> (cons)) \
        else $error("output beat breaks vertex rule");

`endif

/* rtl/core/uvs_pkg.sv */
// Shared types and constants of the UV sphere vertex generator
package uvs_pkg;

    localparam int MAX_STACKS_DEF = 255;
    localparam int MAX_SLICES_DEF = 256;
    localparam int ANGLE_BITS_DEF = 12;
    localparam int QUEUE_DEPTH    = 2;

    localparam int FRAC_BITS = 17;
    localparam int DIV_STEPS = FRAC_BITS + 1;
    localparam int QUO_W     = FRAC_BITS + 1;

    localparam longint unsigned PI_Q30 = 64'd3373259426;
    localparam logic [15:0] ONE_Q14 = 16'd16384;

    localparam logic [1:0] REG_RADIUS = 2'd0;
    localparam logic [1:0] REG_STACKS = 2'd1;
    localparam logic [1:0] REG_SLICES = 2'd2;

    typedef struct packed {
        logic [7:0] stacks;
        logic [8:0] slices;
        logic [8:0] s1;
        logic [8:0] d;
        logic       multi;
    } cfg_t;

    typedef struct packed {
        logic        in_range;
        logic        top;
        logic        bot;
        logic [15:0] vertex_index;
    } side_t;

    typedef struct packed {
        side_t      side;
        logic [8:0] ring_x;
        logic [8:0] slice_x;
    } item_t;

endpackage

/* rtl/core/uvs_queue.sv */
// Short queue between the classifying front and the compute back
module uvs_queue
    import uvs_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t wr_data,
    output logic  not_full,
    input  logic  pop,
    output logic  rd_valid,
    output item_t rd_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    item_t          mem [0:DEPTH-1];
    logic [PW-1:0]  wr_ptr_reg;
    logic [PW-1:0]  wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg;
    logic [PW-1:0]  rd_ptr_next;
    logic [CW-1:0]  count_reg;
    logic [CW-1:0]  count_next;
    logic           do_push;
    logic           do_pop;

    assign not_full = (count_reg != CW'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = mem[rd_ptr_reg];
    assign do_push  = push && not_full;
    assign do_pop   = pop && rd_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

/* rtl/core/uvs_front.sv */
// Front: accept a beat, classify the vertex and form its buffer index
module uvs_front
    import uvs_pkg::*;
(
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [8:0] ring,
    input  logic [7:0] slice,
    input  cfg_t       cfg,
    input  logic       q_not_full,
    output logic       q_push,
    output item_t      q_item
);

    logic        is_top;
    logic        is_bot;
    logic        is_lat;
    logic [7:0]  ring_m1;
    logic [7:0]  mul_a;
    logic [7:0]  add_b;
    logic [16:0] idx_full;

    assign in_ready = q_not_full;
    assign q_push   = in_valid && q_not_full;

    always_comb
    begin
        is_top   = (ring == 9'd0);
        is_bot   = !is_top && (ring == cfg.s1);
        is_lat   = !is_top && (ring <= {1'b0, cfg.stacks}) && ({1'b0, slice} < cfg.slices);
        ring_m1  = ring[7:0] - 8'd1;
        mul_a    = is_bot ? cfg.stacks : ring_m1;
        add_b    = is_bot ? 8'd0 : slice;
        idx_full = {9'd0, mul_a} * {8'd0, cfg.slices} + {9'd0, add_b} + 17'd1;

        q_item.side.in_range     = is_top || is_bot || is_lat;
        q_item.side.top          = is_top;
        q_item.side.bot          = is_bot;
        q_item.side.vertex_index = (is_bot || is_lat) ? idx_full[15:0] : 16'd0;
        q_item.ring_x            = ring;
        q_item.slice_x           = {1'b0, slice};
    end

endmodule

/* rtl/core/uvs_divider.sv */
// Pipelined restoring divider: q = floor(x * 2^FRAC_BITS / den), one bit a stage
module uvs_divider
    import uvs_pkg::*;
(
    input  logic             clk,
    input  logic             en,
    input  logic [8:0]       x,
    input  logic [8:0]       den,
    output logic [QUO_W-1:0] q
);

    logic [9:0]       rem_reg [0:DIV_STEPS-1];
    logic [8:0]       den_reg [0:DIV_STEPS-1];
    logic [QUO_W-1:0] quo_reg [0:DIV_STEPS-1];
    logic             b0;
    logic [8:0]       r0;

    assign b0 = (x >= den);
    assign r0 = b0 ? (x - den) : x;
    assign q  = quo_reg[DIV_STEPS-1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= {1'b0, r0};
            den_reg[0] <= den;
            quo_reg[0] <= {{(QUO_W-1){1'b0}}, b0};
        end
    end

    for (genvar i = 1; i < DIV_STEPS; i++)
    begin : g_step
        logic [10:0] r2;
        logic        bit_q;
        logic [10:0] rn;

        always_comb
        begin
            r2    = {rem_reg[i-1], 1'b0};
            bit_q = (r2 >= {2'b00, den_reg[i-1]});
            rn    = bit_q ? (r2 - {2'b00, den_reg[i-1]}) : r2;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i] <= rn[9:0];
                den_reg[i] <= den_reg[i-1];
                quo_reg[i] <= {quo_reg[i-1][QUO_W-2:0], bit_q};
            end
        end
    end

endmodule

/* rtl/core/uvs_sine_rom.sv */
// Quarter-wave sine ROM in Q1.14, two registered read ports
module uvs_sine_rom
    import uvs_pkg::*;
#(
    parameter int ANGLE_BITS = ANGLE_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  en,
    input  logic [ANGLE_BITS-2:0] addr_a,
    input  logic [ANGLE_BITS-2:0] addr_b,
    output logic [14:0]           data_a,
    output logic [14:0]           data_b
);

    localparam int QN = 1 << (ANGLE_BITS - 2);

    typedef logic [14:0] rom_t [0:QN];

    function automatic rom_t build_rom();
        rom_t              t;
        longint unsigned   xv;
        longint unsigned   x2;
        longint unsigned   t3;
        longint unsigned   t5;
        longint unsigned   t7;
        longint unsigned   t9;
        longint unsigned   s;
        for (int k = 0; k <= QN; k++)
        begin
            xv = (PI_Q30 * longint'(k) + longint'(QN)) >> (ANGLE_BITS - 1);
            x2 = (xv * xv) >> 30;
            t3 = ((xv * x2) >> 30) / 6;
            t5 = ((t3 * x2) >> 30) / 20;
            t7 = ((t5 * x2) >> 30) / 42;
            t9 = ((t7 * x2) >> 30) / 72;
            s  = xv - t3 + t5 - t7 + t9;
            t[k] = 15'((s + 64'd32768) >> 16);
        end
        return t;
    endfunction

    localparam rom_t SINE_ROM = build_rom();

    logic [14:0] data_a_reg;
    logic [14:0] data_b_reg;

    assign data_a = data_a_reg;
    assign data_b = data_b_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_a_reg <= SINE_ROM[addr_a];
            data_b_reg <= SINE_ROM[addr_b];
        end
    end

endmodule

/* rtl/core/uvs_back.sv */
// Back: divide for angles, look up sine and cosine, scale and present the result
module uvs_back
    import uvs_pkg::*;
#(
    parameter int ANGLE_BITS = ANGLE_BITS_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  cfg_t         cfg,
    input  logic [15:0]  radius,
    input  logic         q_valid,
    input  item_t        q_data,
    output logic         q_pop,
    output logic         out_valid,
    input  logic         out_ready,
    output logic [15:0]  vertex_index,
    output logic [16:0]  pos_x,
    output logic [16:0]  pos_y,
    output logic [16:0]  pos_z,
    output logic [15:0]  norm_x,
    output logic [15:0]  norm_y,
    output logic [15:0]  norm_z,
    output logic [16:0]  tex_u,
    output logic [16:0]  tex_v,
    output logic         in_range
);

    localparam int AB = ANGLE_BITS;
    localparam logic [AB-1:0] QUARTER = AB'(1 << (AB - 2));
    localparam logic [AB-2:0] QN_A    = (AB-1)'(1 << (AB - 2));

    function automatic logic [AB-1:0] fold(input logic [AB-1:0] a);
        logic [AB-2:0] r;
        r = {1'b0, a[AB-3:0]};
        return {a[AB-1], (a[AB-2] ? (QN_A - r) : r)};
    endfunction

    function automatic logic [16:0] apply17(input logic neg, input logic [16:0] m);
        return neg ? (~m + 17'd1) : m;
    endfunction

    function automatic logic [15:0] apply16(input logic neg, input logic [15:0] m);
        return neg ? (~m + 16'd1) : m;
    endfunction

    logic adv;

    // divider stages
    side_t            side_reg [0:DIV_STEPS-1];
    logic             sv_reg   [0:DIV_STEPS-1];
    logic [QUO_W-1:0] qr;
    logic [QUO_W-1:0] qs;

    // angle stage
    logic [18:0]   phi_sum;
    logic [18:0]   th_sum;
    logic [18:0]   v_sum;
    logic [18:0]   u_sum;
    logic [AB-1:0] phi;
    logic [AB-1:0] theta;
    logic [AB-1:0] f_sp;
    logic [AB-1:0] f_cp;
    logic [AB-1:0] f_st;
    logic [AB-1:0] f_ct;

    logic          a_valid_reg;
    side_t         a_side_reg;
    logic [AB-2:0] a_sp_addr_reg;
    logic [AB-2:0] a_cp_addr_reg;
    logic [AB-2:0] a_st_addr_reg;
    logic [AB-2:0] a_ct_addr_reg;
    logic [3:0]    a_neg_reg;
    logic [16:0]   a_u_reg;
    logic [16:0]   a_v_reg;

    // table read stage
    logic        r_valid_reg;
    side_t       r_side_reg;
    logic [3:0]  r_neg_reg;
    logic [16:0] r_u_reg;
    logic [16:0] r_v_reg;
    logic [14:0] sp_mag;
    logic [14:0] cp_mag;
    logic [14:0] st_mag;
    logic [14:0] ct_mag;

    // first product stage
    logic [30:0] rsp;
    logic [30:0] py_sum;
    logic [29:0] nx_sum;
    logic [29:0] nz_sum;

    logic        m_valid_reg;
    side_t       m_side_reg;
    logic [3:0]  m_neg_reg;
    logic [16:0] m_u_reg;
    logic [16:0] m_v_reg;
    logic [30:0] m_rsp_reg;
    logic [14:0] m_st_reg;
    logic [14:0] m_ct_reg;
    logic [14:0] m_cp_reg;
    logic [16:0] m_py_reg;
    logic [15:0] m_nx_reg;
    logic [15:0] m_nz_reg;

    // output stage
    logic [45:0] px_sum;
    logic [45:0] pz_sum;
    logic        sg_x;
    logic        sg_z;

    logic        out_valid_reg;
    logic [15:0] vertex_index_reg;
    logic [16:0] pos_x_reg;
    logic [16:0] pos_y_reg;
    logic [16:0] pos_z_reg;
    logic [15:0] norm_x_reg;
    logic [15:0] norm_y_reg;
    logic [15:0] norm_z_reg;
    logic [16:0] tex_u_reg;
    logic [16:0] tex_v_reg;
    logic        in_range_reg;

    logic [15:0] vertex_index_next;
    logic [16:0] pos_x_next;
    logic [16:0] pos_y_next;
    logic [16:0] pos_z_next;
    logic [15:0] norm_x_next;
    logic [15:0] norm_y_next;
    logic [15:0] norm_z_next;
    logic [16:0] tex_u_next;
    logic [16:0] tex_v_next;
    logic        in_range_next;

    assign adv   = !out_valid_reg || out_ready;
    assign q_pop = adv && q_valid;

    uvs_divider u_div_ring
    (
        .clk (clk),
        .en  (adv),
        .x   (q_data.ring_x),
        .den (cfg.s1),
        .q   (qr)
    );

    uvs_divider u_div_slice
    (
        .clk (clk),
        .en  (adv),
        .x   (q_data.slice_x),
        .den (cfg.d),
        .q   (qs)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DIV_STEPS; i++)
            begin
                sv_reg[i] <= 1'b0;
            end
            a_valid_reg   <= 1'b0;
            r_valid_reg   <= 1'b0;
            m_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            sv_reg[0] <= q_valid;
            for (int i = 1; i < DIV_STEPS; i++)
            begin
                sv_reg[i] <= sv_reg[i-1];
            end
            a_valid_reg   <= sv_reg[DIV_STEPS-1];
            r_valid_reg   <= a_valid_reg;
            m_valid_reg   <= r_valid_reg;
            out_valid_reg <= m_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_reg[0] <= q_data.side;
            for (int i = 1; i < DIV_STEPS; i++)
            begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    always_comb
    begin
        phi_sum = {1'b0, qr} + 19'(1 << (17 - AB));
        th_sum  = {1'b0, qs} + 19'(1 << (16 - AB));
        v_sum   = {1'b0, qr} + 19'd1;
        u_sum   = {1'b0, qs} + 19'd1;
        phi     = phi_sum[(18 - AB) +: AB];
        theta   = cfg.multi ? th_sum[(17 - AB) +: AB] : '0;
        f_sp    = fold(phi);
        f_cp    = fold(phi + QUARTER);
        f_st    = fold(theta);
        f_ct    = fold(theta + QUARTER);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_side_reg    <= side_reg[DIV_STEPS-1];
            a_sp_addr_reg <= f_sp[AB-2:0];
            a_cp_addr_reg <= f_cp[AB-2:0];
            a_st_addr_reg <= f_st[AB-2:0];
            a_ct_addr_reg <= f_ct[AB-2:0];
            a_neg_reg     <= {f_ct[AB-1], f_st[AB-1], f_cp[AB-1], f_sp[AB-1]};
            a_u_reg       <= cfg.multi ? u_sum[17:1] : 17'd0;
            a_v_reg       <= v_sum[17:1];
        end
    end

    uvs_sine_rom #(.ANGLE_BITS(AB)) u_rom_phi
    (
        .clk    (clk),
        .en     (adv),
        .addr_a (a_sp_addr_reg),
        .addr_b (a_cp_addr_reg),
        .data_a (sp_mag),
        .data_b (cp_mag)
    );

    uvs_sine_rom #(.ANGLE_BITS(AB)) u_rom_theta
    (
        .clk    (clk),
        .en     (adv),
        .addr_a (a_st_addr_reg),
        .addr_b (a_ct_addr_reg),
        .data_a (st_mag),
        .data_b (ct_mag)
    );

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            r_side_reg <= a_side_reg;
            r_neg_reg  <= a_neg_reg;
            r_u_reg    <= a_u_reg;
            r_v_reg    <= a_v_reg;
        end
    end

    always_comb
    begin
        rsp    = {15'd0, radius} * {16'd0, sp_mag};
        py_sum = {15'd0, radius} * {16'd0, cp_mag} + 31'd8192;
        nx_sum = {15'd0, sp_mag} * {15'd0, ct_mag} + 30'd8192;
        nz_sum = {15'd0, sp_mag} * {15'd0, st_mag} + 30'd8192;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m_side_reg <= r_side_reg;
            m_neg_reg  <= r_neg_reg;
            m_u_reg    <= r_u_reg;
            m_v_reg    <= r_v_reg;
            m_rsp_reg  <= rsp;
            m_st_reg   <= st_mag;
            m_ct_reg   <= ct_mag;
            m_cp_reg   <= cp_mag;
            m_py_reg   <= py_sum[30:14];
            m_nx_reg   <= nx_sum[29:14];
            m_nz_reg   <= nz_sum[29:14];
        end
    end

    always_comb
    begin
        px_sum = {15'd0, m_rsp_reg} * {31'd0, m_ct_reg} + 46'd134217728;
        pz_sum = {15'd0, m_rsp_reg} * {31'd0, m_st_reg} + 46'd134217728;
        sg_x   = m_neg_reg[0] ^ m_neg_reg[3];
        sg_z   = m_neg_reg[0] ^ m_neg_reg[2];

        vertex_index_next = m_side_reg.vertex_index;
        pos_x_next        = '0;
        pos_y_next        = '0;
        pos_z_next        = '0;
        norm_x_next       = '0;
        norm_y_next       = '0;
        norm_z_next       = '0;
        tex_u_next        = '0;
        tex_v_next        = '0;
        in_range_next     = m_side_reg.in_range;

        priority if (!m_side_reg.in_range)
        begin
            vertex_index_next = '0;
        end
        else if (m_side_reg.top)
        begin
            pos_y_next  = {1'b0, radius};
            norm_y_next = ONE_Q14;
        end
        else if (m_side_reg.bot)
        begin
            pos_y_next  = apply17(1'b1, {1'b0, radius});
            norm_y_next = apply16(1'b1, ONE_Q14);
            tex_v_next  = 17'd65536;
        end
        else
        begin
            pos_x_next  = apply17(sg_x, px_sum[44:28]);
            pos_y_next  = apply17(m_neg_reg[1], m_py_reg);
            pos_z_next  = apply17(sg_z, pz_sum[44:28]);
            norm_x_next = apply16(sg_x, m_nx_reg);
            norm_y_next = apply16(m_neg_reg[1], {1'b0, m_cp_reg});
            norm_z_next = apply16(sg_z, m_nz_reg);
            tex_u_next  = m_u_reg;
            tex_v_next  = m_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            vertex_index_reg <= vertex_index_next;
            pos_x_reg        <= pos_x_next;
            pos_y_reg        <= pos_y_next;
            pos_z_reg        <= pos_z_next;
            norm_x_reg       <= norm_x_next;
            norm_y_reg       <= norm_y_next;
            norm_z_reg       <= norm_z_next;
            tex_u_reg        <= tex_u_next;
            tex_v_reg        <= tex_v_next;
            in_range_reg     <= in_range_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign vertex_index = vertex_index_reg;
    assign pos_x        = pos_x_reg;
    assign pos_y        = pos_y_reg;
    assign pos_z        = pos_z_reg;
    assign norm_x       = norm_x_reg;
    assign norm_y       = norm_y_reg;
    assign norm_z       = norm_z_reg;
    assign tex_u        = tex_u_reg;
    assign tex_v        = tex_v_reg;
    assign in_range     = in_range_reg;

endmodule

/* rtl/core/uv_sphere_vertex_generator_top.sv */
// UV sphere vertex generator. Throughput one vertex per cycle while output beats are taken;
// the 18-step divider pipeline and the two dual-port sine tables set the depth.
// The whole back pipeline holds while an output beat waits to be taken.
// Reset clears all valid flags and the queue, and sets radius 256,
// stacks 16 and slices 32.
module uv_sphere_vertex_generator_top
    import uvs_pkg::*;
#(
    parameter int MAX_STACKS = MAX_STACKS_DEF,
    parameter int MAX_SLICES = MAX_SLICES_DEF,
    parameter int ANGLE_BITS = ANGLE_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_idx,
    input  logic [15:0] cfg_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [8:0]  ring,
    input  logic [7:0]  slice,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] vertex_index,
    output logic [16:0] pos_x,
    output logic [16:0] pos_y,
    output logic [16:0] pos_z,
    output logic [15:0] norm_x,
    output logic [15:0] norm_y,
    output logic [15:0] norm_z,
    output logic [16:0] tex_u,
    output logic [16:0] tex_v,
    output logic        in_range
);

    logic [15:0] radius_reg;
    logic [7:0]  num_stacks_reg;
    logic [8:0]  num_slices_reg;
    cfg_t        cfg;
    logic        q_not_full;
    logic        q_push;
    item_t       q_item;
    logic        q_valid;
    item_t       q_data;
    logic        q_pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg     <= 16'd256;
            num_stacks_reg <= 8'd16;
            num_slices_reg <= 9'd32;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                REG_RADIUS: radius_reg     <= cfg_wdata;
                REG_STACKS: num_stacks_reg <= cfg_wdata[7:0];
                REG_SLICES: num_slices_reg <= cfg_wdata[8:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        cfg.stacks = (int'(num_stacks_reg) > MAX_STACKS) ? 8'(MAX_STACKS) : num_stacks_reg;
        cfg.slices = (int'(num_slices_reg) > MAX_SLICES) ? 9'(MAX_SLICES) : num_slices_reg;
        cfg.s1     = {1'b0, cfg.stacks} + 9'd1;
        cfg.d      = cfg.slices - 9'd1;
        cfg.multi  = (cfg.slices > 9'd1);
    end

    uvs_front u_front
    (
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .ring       (ring),
        .slice      (slice),
        .cfg        (cfg),
        .q_not_full (q_not_full),
        .q_push     (q_push),
        .q_item     (q_item)
    );

    uvs_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .wr_data  (q_item),
        .not_full (q_not_full),
        .pop      (q_pop),
        .rd_valid (q_valid),
        .rd_data  (q_data)
    );

    uvs_back #(.ANGLE_BITS(ANGLE_BITS)) u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .radius       (radius_reg),
        .q_valid      (q_valid),
        .q_data       (q_data),
        .q_pop        (q_pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .vertex_index (vertex_index),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .pos_z        (pos_z),
        .norm_x       (norm_x),
        .norm_y       (norm_y),
        .norm_z       (norm_z),
        .tex_u        (tex_u),
        .tex_v        (tex_v),
        .in_range     (in_range)
    );

endmodule

/* rtl/core/uvs_checker.sv */
// Port-level checker of the UV sphere vertex generator, bound to the top level
`include "uv_sphere_vertex_generator_top_assert.svh"

module uvs_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [15:0] vertex_index,
    input logic [16:0] pos_x,
    input logic [16:0] pos_y,
    input logic [15:0] norm_x,
    input logic [15:0] norm_y,
    input logic [16:0] tex_u,
    input logic [16:0] tex_v,
    input logic        in_range
);

    logic oor_zero;
    logic top_ok;
    logic bot_ok;

    assign oor_zero = (vertex_index == 16'd0) && (pos_y == 17'd0) && (tex_v == 17'd0);
    assign top_ok   = (norm_y == 16'd16384) && (norm_x == 16'd0) && (pos_x == 17'd0)
                      && (tex_u == 17'd0);
    assign bot_ok   = in_range && (norm_y == 16'hC000) && (norm_x == 16'd0);

    `UVS_ASSERT_HOLD(a_out_hold, out_valid, out_ready, vertex_index)
    `UVS_ASSERT_IMPL(a_oor_zero, out_valid && !in_range, oor_zero)
    `UVS_ASSERT_IMPL(a_top_pole, out_valid && in_range && tex_v == 17'd0, top_ok)
    `UVS_ASSERT_IMPL(a_bot_pole, out_valid && tex_v == 17'd65536, bot_ok)

endmodule

bind uv_sphere_vertex_generator_top uvs_checker u_uvs_checker (.*);

/* verif/uv_sphere_vertex_generator_top_test.sv */
// Self-checking testbench for the UV sphere vertex generator: random and directed vertices
module uv_sphere_vertex_generator_top_test
    import uvs_pkg::*;
();

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 40;
    localparam int HOLD_CYCLES    = 400;

    typedef struct packed {
        logic [15:0] vertex_index;
        logic [16:0] pos_x;
        logic [16:0] pos_y;
        logic [16:0] pos_z;
        logic [15:0] norm_x;
        logic [15:0] norm_y;
        logic [15:0] norm_z;
        logic [16:0] tex_u;
        logic [16:0] tex_v;
        logic        in_range;
    } vertex_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_idx;
    logic [15:0] cfg_wdata;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [8:0]  ring = '0;
    logic [7:0]  slice = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [15:0] vertex_index;
    logic [16:0] pos_x;
    logic [16:0] pos_y;
    logic [16:0] pos_z;
    logic [15:0] norm_x;
    logic [15:0] norm_y;
    logic [15:0] norm_z;
    logic [16:0] tex_u;
    logic [16:0] tex_v;
    logic        in_range;

    logic [16:0] vertex_req_q[$];
    vertex_t     vertex_exp_q[$];
    logic [15:0] sph_radius;
    logic [7:0]  sph_stacks;
    logic [8:0]  sph_slices;
    int          send_idle;
    int          recv_stall;
    int          hold_req;
    int          hold_seen = 0;
    int          hold_cnt = 0;
    int          fail_cnt = 0;
    int          quiet_cnt = 0;
    logic        in_taken = 1'b0;

    uv_sphere_vertex_generator_top dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata),
        .in_valid(in_valid), .in_ready(in_ready), .ring(ring), .slice(slice),
        .out_valid(out_valid), .out_ready(out_ready), .vertex_index(vertex_index),
        .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z), .norm_x(norm_x), .norm_y(norm_y),
        .norm_z(norm_z), .tex_u(tex_u), .tex_v(tex_v), .in_range(in_range)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    function automatic longint quarter_wave(longint unsigned k);
        longint unsigned x, x2, t3, t5, t7, t9, s;
        x  = (PI_Q30 * k + 1024) / 2048;
        x2 = (x * x) >> 30;
        t3 = ((x * x2) >> 30) / 6;
        t5 = ((t3 * x2) >> 30) / 20;
        t7 = ((t5 * x2) >> 30) / 42;
        t9 = ((t7 * x2) >> 30) / 72;
        s  = x - t3 + t5 - t7 + t9;
        return longint'((s + (64'd1 << 15)) >> 16);
    endfunction

    function automatic longint sin_q14(longint unsigned a);
        longint unsigned quad, r;
        longint v;
        a    = a & 64'hFFF;
        quad = a >> 10;
        r    = a & 64'h3FF;
        v    = quad[0] ? quarter_wave(1024 - r) : quarter_wave(r);
        return (quad >= 2) ? -v : v;
    endfunction

    function automatic longint mul_round(longint a, longint b, int sh);
        longint unsigned ma, mb, m;
        bit neg;
        neg = (a < 0) != (b < 0);
        ma  = (a < 0) ? -a : a;
        mb  = (b < 0) ? -b : b;
        m   = (ma * mb + (64'd1 << (sh - 1))) >> sh;
        return neg ? -longint'(m) : longint'(m);
    endfunction

    function automatic vertex_t sphere_vertex(logic [8:0] rg, logic [7:0] sl);
        vertex_t v;
        longint unsigned stk, slc, s1, phi, theta, u, d;
        longint sp, cp, st, ct, rad;
        v     = '0;
        stk   = sph_stacks;
        slc   = (sph_slices > 256) ? 256 : sph_slices;
        s1    = stk + 1;
        rad   = sph_radius;
        theta = 0;
        u     = 0;
        if (rg == 0)
        begin
            v.pos_y    = rad[16:0];
            v.norm_y   = ONE_Q14;
            v.in_range = 1'b1;
        end
        else if (rg == s1)
        begin
            v.vertex_index = 16'(stk * slc + 1);
            v.pos_y        = 17'(-rad);
            v.norm_y       = 16'(-16384);
            v.tex_v        = 17'd65536;
            v.in_range     = 1'b1;
        end
        else if (rg <= stk && sl < slc)
        begin
            phi = (rg * 4096 + s1) / (2 * s1);
            if (slc > 1)
            begin
                d     = slc - 1;
                theta = (sl * 8192 + d) / (2 * d);
                u     = (sl * 131072 + d) / (2 * d);
            end
            sp = sin_q14(phi);
            cp = sin_q14(phi + 1024);
            st = sin_q14(theta);
            ct = sin_q14(theta + 1024);
            v.vertex_index = 16'(1 + (rg - 1) * slc + sl);
            v.pos_x        = 17'(mul_round(rad * sp, ct, 28));
            v.pos_y        = 17'(mul_round(rad, cp, 14));
            v.pos_z        = 17'(mul_round(rad * sp, st, 28));
            v.norm_x       = 16'(mul_round(sp, ct, 14));
            v.norm_y       = 16'(cp);
            v.norm_z       = 16'(mul_round(sp, st, 14));
            v.tex_u        = 17'(u);
            v.tex_v        = 17'((rg * 131072 + s1) / (2 * s1));
            v.in_range     = 1'b1;
        end
        return v;
    endfunction

    task automatic check_field(string nm, logic [16:0] e, logic [16:0] a);
        if (e !== a)
        begin
            $error("%s expected %h got %h", nm, e, a);
            fail_cnt++;
        end
    endtask

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!in_valid || in_taken)
            begin
                if (vertex_req_q.size() > 0 && $urandom_range(99) >= send_idle)
                begin
                    in_valid <= 1'b1;
                    {ring, slice} <= vertex_req_q.pop_front();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_cnt > 0)
            begin
                out_ready <= 1'b0;
                hold_cnt  <= hold_cnt - 1;
            end
            else if (hold_req != hold_seen)
            begin
                out_ready <= 1'b0;
                hold_cnt  <= HOLD_CYCLES;
                hold_seen <= hold_req;
            end
            else
                out_ready <= ($urandom_range(99) >= recv_stall);
        end
    end

    always @(posedge clk)
    begin
        vertex_t e;
        in_taken <= in_valid && in_ready;
        if (rst_n)
        begin
            if (in_valid && in_ready)
                vertex_exp_q = {vertex_exp_q, sphere_vertex(ring, slice)};
            if (out_valid && out_ready)
            begin
                if (vertex_exp_q.size() == 0)
                begin
                    $error("output beat with no vertex pending");
                    fail_cnt++;
                end
                else
                begin
                    e = vertex_exp_q.pop_front();
                    check_field("vertex_index", {1'b0, e.vertex_index}, {1'b0, vertex_index});
                    check_field("pos_x", e.pos_x, pos_x);
                    check_field("pos_y", e.pos_y, pos_y);
                    check_field("pos_z", e.pos_z, pos_z);
                    check_field("norm_x", {1'b0, e.norm_x}, {1'b0, norm_x});
                    check_field("norm_y", {1'b0, e.norm_y}, {1'b0, norm_y});
                    check_field("norm_z", {1'b0, e.norm_z}, {1'b0, norm_z});
                    check_field("tex_u", e.tex_u, tex_u);
                    check_field("tex_v", e.tex_v, tex_v);
                    check_field("in_range", {16'd0, e.in_range}, {16'd0, in_range});
                end
            end
            if ((in_valid && in_ready) || (out_valid && out_ready)
                || (vertex_req_q.size() == 0 && !in_valid && vertex_exp_q.size() == 0))
                quiet_cnt <= 0;
            else
                quiet_cnt <= quiet_cnt + 1;
            if (quiet_cnt >= WATCHDOG_LIMIT)
            begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic set_sphere(logic [15:0] rad, logic [7:0] stk, logic [8:0] slc);
        write_reg(REG_RADIUS, rad);
        write_reg(REG_STACKS, {8'd0, stk});
        write_reg(REG_SLICES, {7'd0, slc});
        sph_radius = rad;
        sph_stacks = stk;
        sph_slices = slc;
    endtask

    task automatic drain;
        @(posedge clk);
        while (vertex_req_q.size() > 0 || in_valid || vertex_exp_q.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic random_vertices(int n);
        int slc;
        logic [8:0] rg;
        logic [7:0] sl;
        logic [16:0] req;
        slc = (sph_slices > 256) ? 256 : sph_slices;
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(99) < 80)
            begin
                rg = 9'($urandom_range(0, sph_stacks + 1));
                sl = (slc > 0) ? 8'($urandom_range(0, slc - 1)) : 8'($urandom_range(0, 255));
            end
            else
            begin
                rg = 9'($urandom_range(0, 511));
                sl = 8'($urandom_range(0, 255));
            end
            req = {rg, sl};
            vertex_req_q = {vertex_req_q, req};
        end
    endtask

    initial
    begin
        logic [15:0] rad_tab[8];
        logic [7:0]  stk_tab[8];
        logic [8:0]  slc_tab[8];
        rad_tab = '{16'hFFFF, 16'd0, 16'd1, 16'd40000, 16'd300, 16'hAAAA, 16'h5555, 16'd256};
        stk_tab = '{8'd255, 8'd1, 8'd0, 8'd3, 8'd200, 8'd255, 8'd7, 8'd16};
        slc_tab = '{9'd256, 9'd2, 9'd1, 9'd0, 9'd511, 9'd255, 9'd300, 9'd32};
        rst_n      = 1'b0;
        cfg_we     = 1'b0;
        cfg_idx    = REG_RADIUS;
        cfg_wdata  = '0;
        send_idle  = 0;
        recv_stall = 0;
        hold_req   = 0;
        sph_radius = 16'd256;
        sph_stacks = 8'd16;
        sph_slices = 9'd32;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;

        // poles, seams, out-of-range rings and slices under reset values
        vertex_req_q = '{{9'd0, 8'd255}, {9'd17, 8'd0}, {9'd17, 8'd200}, {9'd1, 8'd0},
                         {9'd1, 8'd31}, {9'd16, 8'd31}, {9'd16, 8'd0}, {9'd8, 8'd16},
                         {9'd8, 8'd32}, {9'd18, 8'd0}, {9'd511, 8'd255}, {9'd256, 8'd128},
                         {9'd9, 8'd8}, {9'd4, 8'd24}, {9'd12, 8'd7}, {9'd3, 8'd255},
                         {9'd0, 8'd0}, {9'd255, 8'd1}};
        drain();
        set_sphere(16'hFFFF, 8'd255, 9'd256);
        vertex_req_q = '{{9'd0, 8'd0}, {9'd256, 8'd0}, {9'd255, 8'd255}, {9'd128, 8'd64},
                         {9'd1, 8'd255}, {9'd257, 8'd3}};
        drain();

        for (int p = 0; p < 8; p++)
        begin
            set_sphere(rad_tab[p], stk_tab[p], slc_tab[p]);
            case (p % 4)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 88; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 88; end
                default: begin send_idle = 27; recv_stall = 27; end
            endcase
            if (p == 0)
                hold_req++;
            random_vertices(p == 2 || p == 6 ? 150 : 240);
            drain();
        end

        if (fail_cnt == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
